// ----- design/hdti_pkg.sv -----
// Types and constants shared by the HID device type inference block.
// No dependencies; compiled first.
`default_nettype none

package hdti_pkg;

  typedef enum logic [2:0] {
    DEV_UNKNOWN  = 3'd0,
    DEV_KEYBOARD = 3'd1,
    DEV_MOUSE    = 3'd2,
    DEV_TOUCH    = 3'd3,
    DEV_TABLET   = 3'd4
  } dev_type_t;

  typedef enum logic [1:0] {
    SCAN_UNKNOWN = 2'd0,
    SCAN_TOUCH   = 2'd1,
    SCAN_TABLET  = 2'd2
  } scan_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_PAGE  = 2'd1,
    KIND_USAGE = 2'd2
  } kind_t;

  // Configuration register indexes
  localparam logic [7:0] CFG_VENDOR_ID     = 8'd0;
  localparam logic [7:0] CFG_PRODUCT_ID    = 8'd1;
  localparam logic [7:0] CFG_BOOT_PROTOCOL = 8'd2;
  localparam logic [7:0] CFG_FORCE_TOUCH   = 8'd3;

  // Boot protocol codes
  localparam logic [7:0] PROTO_NONE     = 8'd0;
  localparam logic [7:0] PROTO_KEYBOARD = 8'd1;
  localparam logic [7:0] PROTO_MOUSE    = 8'd2;

  // Descriptor item decode
  localparam logic [7:0]  LONG_ITEM_HDR  = 8'hFE;
  localparam logic [3:0]  TAG_USAGE_PAGE = 4'h0;
  localparam logic [1:0]  TYPE_GLOBAL    = 2'd1;
  localparam logic [1:0]  TYPE_LOCAL     = 2'd2;
  localparam logic [1:0]  SIZE_FOUR      = 2'd3;
  localparam logic [31:0] PAGE_DIGITIZER = 32'h0000_000D;
  localparam logic [31:0] USAGE_DIGITIZER  = 32'h0000_0001;
  localparam logic [31:0] USAGE_PEN        = 32'h0000_0002;
  localparam logic [31:0] USAGE_TOUCHSCRN  = 32'h0000_0004;
  localparam logic [31:0] USAGE_TOUCHPAD   = 32'h0000_0005;

  // Emulated tablet id pair
  localparam logic [15:0] EMU_VENDOR  = 16'h0627;
  localparam logic [15:0] EMU_PRODUCT = 16'h0001;

  // Vendors taken as touchscreens when boot protocol and scan verdict do not decide
  localparam int NUM_TOUCH_VENDORS = 7;
  localparam logic [15:0] TOUCH_VENDORS [NUM_TOUCH_VENDORS] = '{
    16'h27C6, 16'h2AE0, 16'h222A, 16'h0EEF, 16'h0596, 16'h0483, 16'h256C
  };

  typedef struct packed {
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [7:0]  boot_protocol;
    logic        force_touch;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  bytes_seen;
    logic [2:0]  data_left;
    logic [1:0]  data_shift;
    kind_t       item_kind;
    logic [31:0] item_value;
    logic        digitizer_page;
    logic        scan_done;
    scan_t       scan_verdict;
  } scan_state_t;

endpackage

`default_nettype wire

// ----- design/hdti_desc_if.sv -----
// Descriptor byte channel: valid/ready plus one descriptor byte and end mark.
// No dependencies.
`default_nettype none

interface hdti_desc_if;
  logic       valid;
  logic       ready;
  logic [7:0] desc_byte;
  logic       last_byte;

  modport source (output valid, output desc_byte, output last_byte, input ready);
  modport sink   (input valid, input desc_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- design/hdti_result_if.sv -----
// Result channel: valid/ready plus device type and scan verdict.
// No dependencies.
`default_nettype none

interface hdti_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] device_type;
  logic [1:0] scan_type;

  modport source (output valid, output device_type, output scan_type, input ready);
  modport sink   (input valid, input device_type, input scan_type, output ready);
endinterface

`default_nettype wire

// ----- design/hdti_cfg_if.sv -----
// Configuration write channel: valid/ready, register index and write data.
// No dependencies.
`default_nettype none

interface hdti_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/hdti_cfg_regs.sv -----
// Configuration register file for the device type inference block.
// Depends on hdti_pkg and hdti_cfg_if.
`default_nettype none

module hdti_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  hdti_cfg_if.sink         cfg,
  output hdti_pkg::cfg_t   regs
);
  import hdti_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_VENDOR_ID:     regs.vendor_id     <= cfg.data;
        CFG_PRODUCT_ID:    regs.product_id    <= cfg.data;
        CFG_BOOT_PROTOCOL: regs.boot_protocol <= cfg.data[7:0];
        CFG_FORCE_TOUCH:   regs.force_touch   <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/hdti_scan.sv -----
// Short-item descriptor scanner: holds the parse state and produces the
// scan verdict for the byte in the input register. Depends on hdti_pkg.
`default_nettype none

module hdti_scan (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic [7:0]  desc_byte,
  input  wire logic        last_byte,
  output hdti_pkg::scan_t  verdict
);
  import hdti_pkg::*;

  scan_state_t state;
  scan_state_t state_next;

  always_comb begin
    logic        fin;
    logic [31:0] fin_value;
    logic [31:0] merged;
    logic [1:0]  len_code;
    logic [1:0]  item_type;
    logic [3:0]  item_tag;

    state_next = state;
    fin        = 1'b0;
    fin_value  = '0;
    len_code   = desc_byte[1:0];
    item_type  = desc_byte[3:2];
    item_tag   = desc_byte[7:4];
    merged     = state.item_value | ({24'd0, desc_byte} << {state.data_shift, 3'b000});

    if (state.bytes_seen != 2'd2) begin
      state_next.bytes_seen = state.bytes_seen + 2'd1;
    end

    if (!state.scan_done) begin
      if (state.data_left == 3'd0) begin
        if (desc_byte == LONG_ITEM_HDR) begin
          state_next.scan_done    = 1'b1;
          state_next.scan_verdict = SCAN_UNKNOWN;
        end else begin
          if (item_tag == TAG_USAGE_PAGE && item_type == TYPE_GLOBAL) begin
            state_next.item_kind = KIND_PAGE;
          end else if (item_tag == TAG_USAGE_PAGE && item_type == TYPE_LOCAL) begin
            state_next.item_kind = KIND_USAGE;
          end else begin
            state_next.item_kind = KIND_OTHER;
          end
          state_next.item_value = '0;
          state_next.data_shift = 2'd0;
          state_next.data_left  = (len_code == SIZE_FOUR) ? 3'd4 : {1'b0, len_code};
          fin = (len_code == 2'd0);
        end
      end else begin
        state_next.item_value = merged;
        state_next.data_shift = state.data_shift + 2'd1;
        state_next.data_left  = state.data_left - 3'd1;
        fin       = (state.data_left == 3'd1);
        fin_value = merged;
      end
    end

    // item complete: update page tracking or decide on a digitizer usage
    if (fin) begin
      if (state_next.item_kind == KIND_PAGE) begin
        state_next.digitizer_page = (fin_value == PAGE_DIGITIZER);
      end else if (state_next.item_kind == KIND_USAGE && state.digitizer_page) begin
        if (fin_value == USAGE_TOUCHSCRN || fin_value == USAGE_DIGITIZER ||
            fin_value == USAGE_TOUCHPAD) begin
          state_next.scan_done    = 1'b1;
          state_next.scan_verdict = SCAN_TOUCH;
        end else if (fin_value == USAGE_PEN) begin
          state_next.scan_done    = 1'b1;
          state_next.scan_verdict = SCAN_TABLET;
        end
      end
    end

    if (state_next.bytes_seen != 2'd2 || !state_next.scan_done) begin
      verdict = SCAN_UNKNOWN;
    end else begin
      verdict = state_next.scan_verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      if (last_byte) begin
        state <= '0;
      end else begin
        state <= state_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/hdti_decide.sv -----
// Final device type decision from boot protocol, scan verdict and ids.
// Depends on hdti_pkg.
`default_nettype none

module hdti_decide (
  input  wire hdti_pkg::cfg_t  regs,
  input  wire hdti_pkg::scan_t verdict,
  output hdti_pkg::dev_type_t  device_type
);
  import hdti_pkg::*;

  logic vendor_hit;

  always_comb begin
    vendor_hit = 1'b0;
    for (int i = 0; i < NUM_TOUCH_VENDORS; i++) begin
      if (TOUCH_VENDORS[i] == regs.vendor_id) begin
        vendor_hit = 1'b1;
      end
    end
  end

  always_comb begin
    if (regs.boot_protocol == PROTO_KEYBOARD) begin
      device_type = DEV_KEYBOARD;
    end else if (regs.boot_protocol == PROTO_MOUSE) begin
      device_type = DEV_MOUSE;
    end else if (regs.boot_protocol != PROTO_NONE) begin
      device_type = DEV_UNKNOWN;
    end else if (verdict == SCAN_TOUCH) begin
      device_type = DEV_TOUCH;
    end else if (verdict == SCAN_TABLET) begin
      device_type = DEV_TABLET;
    end else if (vendor_hit) begin
      device_type = DEV_TOUCH;
    end else if (regs.vendor_id == EMU_VENDOR && regs.product_id == EMU_PRODUCT) begin
      device_type = regs.force_touch ? DEV_TOUCH : DEV_TABLET;
    end else begin
      device_type = DEV_TOUCH;
    end
  end

endmodule

`default_nettype wire

// ----- design/hid_device_type_infer.sv -----
// Top level of the HID device type inference block.
// Depends on hdti_pkg, the three channel interfaces, hdti_cfg_regs,
// hdti_scan and hdti_decide.
//
//  channel | dir | payload                       | beat means
//  --------+-----+-------------------------------+---------------------------
//  desc    | in  | desc_byte[7:0], last_byte     | one descriptor byte
//  result  | out | device_type[2:0], scan_type   | one verdict per descriptor
//  cfg     | in  | index[7:0], data[15:0]        | one register write
//
// Cycles: one descriptor byte per clock sustained while no last byte stalls. A byte
//   sits in the input register, the scanner and decision logic run in that cycle,
//   and the verdict for a last byte is then registered into the result register.
// Reset (rst, synchronous) clears the scan state, input/result valids and
//   all config registers.
// Stalls: only a last byte waits on a full result register; other bytes
//   keep flowing while an earlier result is still pending.
// cfg is always ready; indexes past the register list are dropped.
`default_nettype none

module hid_device_type_infer (
  input  wire logic    clk,
  input  wire logic    rst,
  hdti_desc_if.sink    desc,
  hdti_result_if.source result,
  hdti_cfg_if.sink     cfg
);
  import hdti_pkg::*;

  cfg_t       regs;
  scan_t      verdict;
  dev_type_t  dev_type;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // result register
  logic       out_valid;
  dev_type_t  out_dev;
  scan_t      out_scan;

  logic       out_free;
  logic       advance;

  assign out_free   = !out_valid || result.ready;
  // a non-final byte never produces a beat, so it never waits on the output
  assign advance    = s1_valid && (!s1_last || out_free);
  assign desc.ready = !s1_valid || advance;

  hdti_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  hdti_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .desc_byte (s1_byte),
    .last_byte (s1_last),
    .verdict   (verdict)
  );

  hdti_decide u_decide (
    .regs        (regs),
    .verdict     (verdict),
    .device_type (dev_type)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (desc.ready) begin
      s1_valid <= desc.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (desc.ready && desc.valid) begin
      s1_byte <= desc.desc_byte;
      s1_last <= desc.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last) begin
      out_dev  <= dev_type;
      out_scan <= verdict;
    end
  end

  assign result.valid       = out_valid;
  assign result.device_type = out_dev;
  assign result.scan_type   = out_scan;

endmodule

`default_nettype wire
